### design/mca_pkg.sv
// ----------------------------------------------------------------------------
// mca_pkg - shared types and constants of the min-cost assignment block
// widths, node numbering and the control/status structs of the solver
// ----------------------------------------------------------------------------
`default_nettype none

package mca_pkg;

  localparam int MAX_SIZE = 8;
  localparam int IDX_W    = $clog2(MAX_SIZE);
  localparam int SIZE_W   = 4;
  localparam int NODE_MAX = 2 * MAX_SIZE + 2;
  localparam int NODE_W   = $clog2(NODE_MAX);
  localparam int COST_W   = 20;
  localparam int DIST_W   = 28;
  localparam int TOTAL_W  = 26;
  localparam int ADDR_W   = 2 * IDX_W;
  localparam int APB_W    = 32;
  localparam int PADDR_W  = 3;

  localparam logic REG_MATRIX_SIZE = 1'b0;

  typedef logic [COST_W-1:0]        cost_t;
  typedef logic [NODE_W-1:0]        node_t;
  typedef logic signed [DIST_W-1:0] dist_t;
  typedef logic [IDX_W-1:0]         idx_t;
  typedef logic [SIZE_W-1:0]        msize_t;
  typedef logic [TOTAL_W-1:0]       total_t;
  typedef logic [ADDR_W-1:0]        maddr_t;

  typedef struct packed {
    logic   start;
    msize_t n;
    idx_t   rd_row;
  } sol_ctl_t;

  typedef struct packed {
    logic   done;
    total_t total;
    msize_t rd_col;
  } sol_stat_t;

endpackage

`default_nettype wire

### design/mca_in_if.sv
// ----------------------------------------------------------------------------
// mca_in_if - cost input channel
// valid/ready handshake carrying one matrix cost per transaction
// ----------------------------------------------------------------------------
`default_nettype none

interface mca_in_if;
  import mca_pkg::*;
  logic  valid;
  logic  ready;
  cost_t cost;
  modport source (output valid, output cost, input ready);
  modport sink   (input valid, input cost, output ready);
endinterface

`default_nettype wire

### design/mca_out_if.sv
// ----------------------------------------------------------------------------
// mca_out_if - assignment result channel
// valid/ready handshake carrying one row/column pair per transaction
// ----------------------------------------------------------------------------
`default_nettype none

interface mca_out_if;
  import mca_pkg::*;
  logic   valid;
  logic   ready;
  msize_t row;
  msize_t column;
  total_t total_cost;
  logic   last;
  modport source (output valid, output row, output column, output total_cost,
                  output last, input ready);
  modport sink   (input valid, input row, input column, input total_cost,
                  input last, output ready);
endinterface

`default_nettype wire

### design/mca_cfg.sv
// ----------------------------------------------------------------------------
// mca_cfg - configuration registers
// apb-style port holding the matrix size, clamped into its legal range
// ----------------------------------------------------------------------------
`default_nettype none

module mca_cfg (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [mca_pkg::PADDR_W-1:0] paddr,
  input  wire logic [mca_pkg::APB_W-1:0]   pwdata,
  output logic      [mca_pkg::APB_W-1:0]   prdata,
  output logic                             pready,
  output mca_pkg::msize_t                  size_r,
  output logic                             size_wr
);
  import mca_pkg::*;

  msize_t wval;
  msize_t size_nxt;

  assign pready  = 1'b1;
  assign size_wr = psel && penable && pwrite && (paddr[2] == REG_MATRIX_SIZE);

  always_comb begin
    wval     = pwdata[SIZE_W-1:0];
    size_nxt = wval;
    if (wval == '0) begin
      size_nxt = SIZE_W'(1);
    end else if (wval > SIZE_W'(MAX_SIZE)) begin
      size_nxt = SIZE_W'(MAX_SIZE);
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_MATRIX_SIZE) begin
      prdata = {{(APB_W-SIZE_W){1'b0}}, size_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r <= SIZE_W'(MAX_SIZE);
    end else if (size_wr) begin
      size_r <= size_nxt;
    end
  end

endmodule

`default_nettype wire

### design/mca_cost_mem.sv
// ----------------------------------------------------------------------------
// mca_cost_mem - cost matrix store
// one write port, one read port with registered data
// ----------------------------------------------------------------------------
`default_nettype none

module mca_cost_mem (
  input  wire logic            clk,
  input  wire logic            we,
  input  wire mca_pkg::maddr_t waddr,
  input  wire mca_pkg::cost_t  wdata,
  input  wire mca_pkg::maddr_t raddr,
  output mca_pkg::cost_t       rdata_r
);
  import mca_pkg::*;

  cost_t mem [MAX_SIZE*MAX_SIZE];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

endmodule

`default_nettype wire

### design/mca_solver.sv
// ----------------------------------------------------------------------------
// mca_solver - shortest augmenting path sequencer
// fifo label-correcting search with one shared add/compare unit per edge
// ----------------------------------------------------------------------------
`default_nettype none

module mca_solver (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire mca_pkg::sol_ctl_t ctl,
  output mca_pkg::sol_stat_t     stat,
  output mca_pkg::maddr_t        mem_raddr,
  input  wire mca_pkg::cost_t    mem_rdata
);
  import mca_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_INIT  = 3'd1;
  localparam logic [2:0] S_POP   = 3'd2;
  localparam logic [2:0] S_EADDR = 3'd3;
  localparam logic [2:0] S_EVAL  = 3'd4;
  localparam logic [2:0] S_AUG   = 3'd5;
  localparam logic [2:0] S_NEXT  = 3'd6;
  localparam logic [2:0] S_DONE  = 3'd7;

  logic [2:0]          state_r, state_nxt;
  msize_t              n_r, round_r;
  dist_t               dist_r   [NODE_MAX];
  node_t               parent_r [NODE_MAX];
  node_t               queue_r  [NODE_MAX];
  logic [NODE_MAX-1:0] reached_r, inq_r;
  node_t               head_r, tail_r, cnt_r;
  node_t               u_r, v_r, au_r;
  dist_t               du_r;
  msize_t              pu_r, k_r;
  logic                open_r, usecost_r, neg_r, lastk_r;
  msize_t              rpart_r [MAX_SIZE];
  msize_t              cpart_r [MAX_SIZE];
  logic [MAX_SIZE-1:0] rmat_r, cmat_r;
  total_t              total_r;
  maddr_t              raddr_r;

  node_t  n5, sink, hq, dsel, p;
  dist_t  dist_rd, w, d, cost_ext;
  idx_t   rp_addr, cp_addr, km1, urow, ucol;
  msize_t pu_nxt, rd_col;
  logic   hq_row, u_src, u_row, u_col, ext, better;
  node_t  v_e;
  logic   open_e, usecost_e, neg_e, lastk_e;
  maddr_t raddr_e;

  always_comb begin
    n5   = {1'b0, n_r};
    sink = {n_r, 1'b1};
    hq   = queue_r[head_r];
    dsel = v_r;
    if (state_r == S_POP) begin
      dsel = (cnt_r == '0) ? sink : hq;
    end
    dist_rd = dist_r[dsel];

    // partner of the node being popped
    hq_row  = (hq != '0) && (hq <= n5);
    rp_addr = (state_r == S_IDLE) ? ctl.rd_row : IDX_W'(hq - NODE_W'(1));
    cp_addr = IDX_W'(hq - n5 - NODE_W'(1));
    rd_col  = rmat_r[rp_addr] ? rpart_r[rp_addr] : '0;
    if (hq_row) begin
      pu_nxt = rd_col;
    end else begin
      pu_nxt = cmat_r[cp_addr] ? cpart_r[cp_addr] : '0;
    end

    // edge k of the current node
    u_src = (u_r == '0);
    u_row = !u_src && (u_r <= n5);
    u_col = (u_r > n5) && (u_r < sink);
    km1   = IDX_W'(k_r - SIZE_W'(1));
    urow  = IDX_W'(u_r - NODE_W'(1));
    ucol  = IDX_W'(u_r - n5 - NODE_W'(1));
    ext   = ({1'b0, k_r} == n5 + NODE_W'(1));
    v_e       = n5 + NODE_W'(k_r);
    open_e    = cmat_r[km1];
    usecost_e = 1'b0;
    neg_e     = 1'b0;
    lastk_e   = (k_r == n_r);
    raddr_e   = raddr_r;
    if (u_src) begin
      v_e    = NODE_W'(k_r);
      open_e = !rmat_r[km1];
    end else if (u_row) begin
      lastk_e = ext;
      if (ext) begin
        v_e    = '0;
        open_e = (pu_r != '0);
      end else begin
        open_e    = (pu_r != k_r);
        usecost_e = 1'b1;
        raddr_e   = {urow, km1};
      end
    end else if (u_col) begin
      lastk_e = ext;
      if (ext) begin
        v_e    = sink;
        open_e = (pu_r == '0);
      end else begin
        v_e       = NODE_W'(k_r);
        open_e    = (pu_r == k_r);
        usecost_e = 1'b1;
        neg_e     = 1'b1;
        raddr_e   = {km1, ucol};
      end
    end

    // shared add/compare
    cost_ext = DIST_W'(mem_rdata);
    w = '0;
    if (usecost_r) begin
      w = neg_r ? -cost_ext : cost_ext;
    end
    d      = du_r + w;
    better = !reached_r[v_r] || (d < dist_rd);

    p = parent_r[au_r];
  end

  // address presented during the edge setup cycle, data ready for the evaluate cycle
  assign mem_raddr   = raddr_e;
  assign stat.done   = (state_r == S_DONE);
  assign stat.total  = total_r;
  assign stat.rd_col = rd_col;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (ctl.start) state_nxt = S_INIT;
      S_INIT:  state_nxt = S_POP;
      S_POP: begin
        if (cnt_r != '0) begin
          state_nxt = S_EADDR;
        end else begin
          state_nxt = reached_r[sink] ? S_AUG : S_DONE;
        end
      end
      S_EADDR: state_nxt = S_EVAL;
      S_EVAL:  state_nxt = lastk_r ? S_POP : S_EADDR;
      S_AUG:   if (p == '0) state_nxt = S_NEXT;
      S_NEXT:  state_nxt = (round_r + SIZE_W'(1) == n_r) ? S_DONE : S_INIT;
      S_DONE:  state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        if (ctl.start) begin
          n_r     <= ctl.n;
          round_r <= '0;
          total_r <= '0;
          rmat_r  <= '0;
          cmat_r  <= '0;
        end
      end
      S_INIT: begin
        reached_r  <= NODE_MAX'(1);
        inq_r      <= NODE_MAX'(1);
        dist_r[0]  <= '0;
        queue_r[0] <= '0;
        head_r     <= '0;
        tail_r     <= NODE_W'(1);
        cnt_r      <= NODE_W'(1);
      end
      S_POP: begin
        if (cnt_r != '0) begin
          u_r       <= hq;
          du_r      <= dist_rd;
          pu_r      <= pu_nxt;
          k_r       <= SIZE_W'(1);
          head_r    <= (head_r == NODE_W'(NODE_MAX-1)) ? '0 : head_r + NODE_W'(1);
          cnt_r     <= cnt_r - NODE_W'(1);
          inq_r[hq] <= 1'b0;
        end else begin
          if (reached_r[sink]) begin
            total_r <= total_r + dist_rd[TOTAL_W-1:0];
          end
          au_r    <= sink;
        end
      end
      S_EADDR: begin
        v_r       <= v_e;
        open_r    <= open_e;
        usecost_r <= usecost_e;
        neg_r     <= neg_e;
        lastk_r   <= lastk_e;
        raddr_r   <= raddr_e;
      end
      S_EVAL: begin
        if (open_r && better) begin
          dist_r[v_r]    <= d;
          reached_r[v_r] <= 1'b1;
          parent_r[v_r]  <= u_r;
          if (!inq_r[v_r]) begin
            queue_r[tail_r] <= v_r;
            tail_r <= (tail_r == NODE_W'(NODE_MAX-1)) ? '0 : tail_r + NODE_W'(1);
            cnt_r  <= cnt_r + NODE_W'(1);
            inq_r[v_r] <= 1'b1;
          end
        end
        k_r <= k_r + SIZE_W'(1);
      end
      S_AUG: begin
        if ((p != '0) && (p <= n5) && (au_r > n5) && (au_r < sink)) begin
          rpart_r[IDX_W'(p - NODE_W'(1))]        <= SIZE_W'(au_r - n5);
          rmat_r[IDX_W'(p - NODE_W'(1))]         <= 1'b1;
          cpart_r[IDX_W'(au_r - n5 - NODE_W'(1))] <= SIZE_W'(p);
          cmat_r[IDX_W'(au_r - n5 - NODE_W'(1))]  <= 1'b1;
        end
        au_r <= p;
      end
      S_NEXT: round_r <= round_r + SIZE_W'(1);
      default: ;
    endcase
  end

endmodule

`default_nettype wire

### design/min_cost_assignment.sv
// ----------------------------------------------------------------------------
// min_cost_assignment - minimum-cost assignment of rows to columns
// loads an n by n cost matrix, solves it by successive shortest augmenting
// paths and streams out one row/column pair per row
// ----------------------------------------------------------------------------
//  channel   direction  transaction
//  in_chan   in         one cost, row-major order
//  out_chan  out        row, column, total cost, last flag
//  apb       in         matrix size register at byte address 0
//
//  loading takes one cost per cycle while in_chan.valid is high; the final
//  cost of the matrix starts the solve, during which in_chan.ready is low
//  each of the n search rounds evaluates the edges of every popped node one
//  at a time through the single add/compare unit, each waiting on the
//  registered read of the cost memory; then the augment walk, one node a cycle
//  results go out one per cycle while out_chan.ready is high, then loading
//  resumes; synchronous active-low reset, no clearing pass needed
// ----------------------------------------------------------------------------
`default_nettype none

module min_cost_assignment (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  mca_in_if.sink                           in_chan,
  mca_out_if.source                        out_chan,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [mca_pkg::PADDR_W-1:0] paddr,
  input  wire logic [mca_pkg::APB_W-1:0]   pwdata,
  output logic      [mca_pkg::APB_W-1:0]   prdata,
  output logic                             pready
);
  import mca_pkg::*;

  localparam logic [1:0] T_LOAD  = 2'd0;
  localparam logic [1:0] T_SOLVE = 2'd1;
  localparam logic [1:0] T_OUT   = 2'd2;

  logic [1:0] state_r, state_nxt;
  idx_t       row_r, col_r, oidx_r;
  msize_t     size_r;
  logic       size_wr;
  idx_t       nm1;
  logic       in_acc, out_acc, mat_end;
  sol_ctl_t   sctl;
  sol_stat_t  sstat;
  maddr_t     mem_raddr;
  cost_t      mem_rdata;

  // configuration register
  mca_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .size_r  (size_r),
    .size_wr (size_wr)
  );

  // cost matrix, written at {row, column}
  mca_cost_mem u_mem (
    .clk     (clk),
    .we      (in_acc),
    .waddr   ({row_r, col_r}),
    .wdata   (in_chan.cost),
    .raddr   (mem_raddr),
    .rdata_r (mem_rdata)
  );

  mca_solver u_sol (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (sctl),
    .stat      (sstat),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  assign nm1     = IDX_W'(size_r - SIZE_W'(1));
  assign in_acc  = in_chan.valid && in_chan.ready;
  assign out_acc = out_chan.valid && out_chan.ready;
  assign mat_end = (row_r == nm1) && (col_r == nm1);

  assign in_chan.ready = (state_r == T_LOAD);

  // solver kicked on the transaction carrying the final cost
  assign sctl.start  = in_acc && mat_end;
  assign sctl.n      = size_r;
  assign sctl.rd_row = oidx_r;

  // results read straight from the solver's partner table
  assign out_chan.valid      = (state_r == T_OUT);
  assign out_chan.row        = SIZE_W'(oidx_r) + SIZE_W'(1);
  assign out_chan.column     = sstat.rd_col;
  assign out_chan.total_cost = sstat.total;
  assign out_chan.last       = (oidx_r == nm1);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      T_LOAD:  if (in_acc && mat_end) state_nxt = T_SOLVE;
      T_SOLVE: if (sstat.done) state_nxt = T_OUT;
      T_OUT:   if (out_acc && out_chan.last) state_nxt = T_LOAD;
      default: state_nxt = T_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= T_LOAD;
      row_r   <= '0;
      col_r   <= '0;
      oidx_r  <= '0;
    end else begin
      state_r <= state_nxt;
      if (size_wr) begin
        // a size write restarts loading
        row_r <= '0;
        col_r <= '0;
      end else if (in_acc) begin
        if (col_r == nm1) begin
          col_r <= '0;
          row_r <= (row_r == nm1) ? '0 : row_r + IDX_W'(1);
        end else begin
          col_r <= col_r + IDX_W'(1);
        end
      end
      if (state_r == T_SOLVE) begin
        oidx_r <= '0;
      end else if (out_acc) begin
        oidx_r <= oidx_r + IDX_W'(1);
      end
    end
  end

endmodule

`default_nettype wire
